FILE: rtl/wsfp_pkg.sv
// ----------------------------------------------------------------------------
// wsfp_pkg
// Shared types and constants of the WebSocket frame parser: parse phases,
// result kinds, header field masks and the result record.
// ----------------------------------------------------------------------------
package wsfp_pkg;

    // Field widths.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned OPCODE_W = 4;
    localparam int unsigned LEN_W    = 64;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned CNT_W    = 3;
    localparam int unsigned KIDX_W   = 2;

    // Output tdata: fin, opcode, mask, length, data, padded to whole bytes.
    localparam int unsigned OUT_FIELDS_W = 1 + OPCODE_W + 1 + LEN_W + BYTE_W;
    localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Parse phases.
    localparam logic [PHASE_W-1:0] PH_FIRST   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SECOND  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_EXT     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_KEY     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_HEADER     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA       = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INCOMPLETE = 2'd2;

    // Header byte fields.
    localparam logic [BYTE_W-1:0] HDR_TOP_BIT  = 8'h80;
    localparam logic [BYTE_W-1:0] HDR_OPCODE   = 8'h0F;
    localparam logic [BYTE_W-1:0] HDR_LEN7     = 8'h7F;
    localparam logic [6:0]        LEN7_EXT16   = 7'd126;
    localparam logic [6:0]        LEN7_EXT64   = 7'd127;

    // Extension bytes still due after the first one, and key length.
    localparam logic [CNT_W-1:0]  EXT16_MORE   = 3'd1;
    localparam logic [CNT_W-1:0]  EXT64_MORE   = 3'd7;
    localparam logic [CNT_W-1:0]  KEY_BYTES    = 3'd4;

    // One result item.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic                fin_flag;
        logic [OPCODE_W-1:0] frame_opcode;
        logic                is_masked;
        logic [LEN_W-1:0]    payload_length;
        logic [BYTE_W-1:0]   data_out;
        logic                last;
    } t_result;

endpackage

FILE: rtl/websocket_frame_parser.sv
// ----------------------------------------------------------------------------
// websocket_frame_parser
// Byte-serial WebSocket frame header parser and payload unmasker.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one stream byte per request in s_axis_tdata;
//   s_axis_tlast marks the last byte of a buffer. The master channel gives at
//   most one result per input byte: m_axis_tuser is the kind (header, payload
//   byte, incomplete frame), m_axis_tdata packs FIN, opcode, mask bit,
//   payload length and the unmasked byte, and m_axis_tlast marks the last
//   result of a frame or an incomplete-frame result.
//   Bytes that produce no result (most header bytes) are consumed silently.
//   An accepted byte passes through the input register, then through the parse
//   logic into the result register. Throughput is one byte per cycle while the
//   receiver does not stall, set by the single parse step between those two
//   registers; the parser state updates once per byte.
//   When the receiver stalls, the result register holds its request and the
//   input register takes one more byte only if it is empty; once it is full,
//   s_axis_tready stays low until the result is taken.
//   Reset (synchronous, active low) empties both registers and returns the
//   parser to expecting the first byte of a new frame.
// ----------------------------------------------------------------------------
module websocket_frame_parser
    import wsfp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tlast,   // end_of_buffer
    // Result stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] fin_flag, [4:1] frame_opcode, [5] is_masked,
    // [69:6] payload_length, [77:70] data_out, [79:78] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [KIND_W-1:0]      m_axis_tuser,   // [1:0] kind
    output logic                   m_axis_tlast    // last
);

    // Input register.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_eob;

    // Parser state.
    logic [PHASE_W-1:0]  r_phase,     n_phase;
    logic [CNT_W-1:0]    r_ext_left,  n_ext_left;
    logic                r_fin,       n_fin;
    logic [OPCODE_W-1:0] r_opcode,    n_opcode;
    logic                r_masked,    n_masked;
    logic [LEN_W-1:0]    r_length,    n_length;
    logic [KEY_W-1:0]    r_key,       n_key;
    logic [CNT_W-1:0]    r_key_left,  n_key_left;
    logic [LEN_W-1:0]    r_pay_left,  n_pay_left;
    logic [KIDX_W-1:0]   r_key_idx,   n_key_idx;

    // Result register.
    logic    r_out_valid;
    t_result r_out;

    // Parse step outputs.
    logic              w_res_valid;
    logic [KIND_W-1:0] w_res_kind;
    logic [BYTE_W-1:0] w_res_data;
    logic              w_res_last;
    logic              w_len_done;
    logic              w_hdr_done;
    logic              w_fire;
    logic              w_out_free;
    logic [BYTE_W-1:0] w_key_byte;
    logic              w_final_byte;
    logic [6:0]        w_len7;

    // Handshake: the parse step fires when a byte waits and the result
    // register is free or being emptied.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_fire;

    // Key byte for the current payload position, first key byte first.
    always_comb begin
        case (r_key_idx)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    assign w_final_byte = (r_pay_left <= {{(LEN_W-1){1'b0}}, 1'b1});
    assign w_len7       = r_in_byte[6:0] & HDR_LEN7[6:0];

    // Parse step for the byte in the input register.
    always_comb begin
        n_phase    = r_phase;
        n_ext_left = r_ext_left;
        n_fin      = r_fin;
        n_opcode   = r_opcode;
        n_masked   = r_masked;
        n_length   = r_length;
        n_key      = r_key;
        n_key_left = r_key_left;
        n_pay_left = r_pay_left;
        n_key_idx  = r_key_idx;
        w_res_valid = 1'b0;
        w_res_kind  = KIND_HEADER;
        w_res_data  = '0;
        w_res_last  = 1'b0;
        w_len_done  = 1'b0;
        w_hdr_done  = 1'b0;

        case (r_phase)
            PH_FIRST: begin
                n_fin    = |(r_in_byte & HDR_TOP_BIT);
                n_opcode = OPCODE_W'(r_in_byte & HDR_OPCODE);
                n_masked = 1'b0;
                n_length = '0;
                n_key    = '0;
                n_phase  = PH_SECOND;
                if (r_in_eob) begin
                    n_phase     = PH_FIRST;
                    w_res_valid = 1'b1;
                    w_res_kind  = KIND_INCOMPLETE;
                    w_res_last  = 1'b1;
                end
            end
            PH_SECOND: begin
                n_masked = |(r_in_byte & HDR_TOP_BIT);
                if (w_len7 == LEN7_EXT16 || w_len7 == LEN7_EXT64) begin
                    n_length   = '0;
                    n_ext_left = (w_len7 == LEN7_EXT16) ? EXT16_MORE : EXT64_MORE;
                    n_phase    = PH_EXT;
                    if (r_in_eob) begin
                        n_phase     = PH_FIRST;
                        w_res_valid = 1'b1;
                        w_res_kind  = KIND_INCOMPLETE;
                        w_res_last  = 1'b1;
                    end
                end else begin
                    n_length   = {{(LEN_W-7){1'b0}}, w_len7};
                    w_len_done = 1'b1;
                end
            end
            PH_EXT: begin
                n_length = {r_length[LEN_W-BYTE_W-1:0], r_in_byte};
                if (r_ext_left == '0) begin
                    w_len_done = 1'b1;
                end else begin
                    n_ext_left = r_ext_left - 1'b1;
                    if (r_in_eob) begin
                        n_phase     = PH_FIRST;
                        w_res_valid = 1'b1;
                        w_res_kind  = KIND_INCOMPLETE;
                        w_res_last  = 1'b1;
                    end
                end
            end
            PH_KEY: begin
                n_key      = {r_key[KEY_W-BYTE_W-1:0], r_in_byte};
                n_key_left = r_key_left - 1'b1;
                if (n_key_left == '0) begin
                    w_hdr_done = 1'b1;
                end else if (r_in_eob) begin
                    n_phase     = PH_FIRST;
                    w_res_valid = 1'b1;
                    w_res_kind  = KIND_INCOMPLETE;
                    w_res_last  = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                w_res_valid = 1'b1;
                if (!w_final_byte && r_in_eob) begin
                    n_phase    = PH_FIRST;
                    w_res_kind = KIND_INCOMPLETE;
                    w_res_last = 1'b1;
                end else begin
                    n_key_idx  = r_key_idx + 1'b1;
                    w_res_kind = KIND_DATA;
                    w_res_data = r_in_byte ^ (r_masked ? w_key_byte : '0);
                    w_res_last = w_final_byte;
                    if (w_final_byte) begin
                        n_pay_left = '0;
                        n_phase    = PH_FIRST;
                    end else begin
                        n_pay_left = r_pay_left - 1'b1;
                    end
                end
            end
            default: begin
                n_phase     = PH_FIRST;
                w_res_valid = 1'b1;
                w_res_kind  = KIND_INCOMPLETE;
                w_res_last  = 1'b1;
            end
        endcase

        // Length known: collect a mask key or finish the header.
        if (w_len_done) begin
            if (n_masked) begin
                if (r_in_eob) begin
                    n_phase     = PH_FIRST;
                    w_res_valid = 1'b1;
                    w_res_kind  = KIND_INCOMPLETE;
                    w_res_last  = 1'b1;
                end else begin
                    n_key_left = KEY_BYTES;
                    n_phase    = PH_KEY;
                end
            end else begin
                w_hdr_done = 1'b1;
            end
        end

        // Header complete: report it and set up the payload count.
        if (w_hdr_done) begin
            w_res_valid = 1'b1;
            w_res_last  = 1'b1;
            n_phase     = PH_FIRST;
            if (n_length == '0) begin
                w_res_kind = KIND_HEADER;
            end else if (r_in_eob) begin
                w_res_kind = KIND_INCOMPLETE;
            end else begin
                w_res_kind = KIND_HEADER;
                w_res_last = 1'b0;
                n_pay_left = n_length;
                n_key_idx  = '0;
                n_phase    = PH_PAYLOAD;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_eob  <= s_axis_tlast;
        end
    end

    // Parser state, updated once per parsed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FIRST;
            r_ext_left <= '0;
            r_fin      <= 1'b0;
            r_opcode   <= '0;
            r_masked   <= 1'b0;
            r_length   <= '0;
            r_key      <= '0;
            r_key_left <= '0;
            r_pay_left <= '0;
            r_key_idx  <= '0;
        end else if (w_fire) begin
            r_phase    <= n_phase;
            r_ext_left <= n_ext_left;
            r_fin      <= n_fin;
            r_opcode   <= n_opcode;
            r_masked   <= n_masked;
            r_length   <= n_length;
            r_key      <= n_key;
            r_key_left <= n_key_left;
            r_pay_left <= n_pay_left;
            r_key_idx  <= n_key_idx;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_fire && w_res_valid) begin
            r_out.kind           <= w_res_kind;
            r_out.fin_flag       <= n_fin;
            r_out.frame_opcode   <= n_opcode;
            r_out.is_masked      <= n_masked;
            r_out.payload_length <= n_length;
            r_out.data_out       <= w_res_data;
            r_out.last           <= w_res_last;
        end
    end

    // Output packing.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                            r_out.data_out, r_out.payload_length,
                            r_out.is_masked, r_out.frame_opcode, r_out.fin_flag};

    // An incomplete-frame result always closes the frame.
    a_incomplete_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_INCOMPLETE) |-> r_out.last)
        else $error("incomplete result without last");

    // Only payload results carry a data byte.
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind != KIND_DATA) |-> (r_out.data_out == '0))
        else $error("nonzero data on a non-payload result");

    // A header result is last exactly when the frame has no payload.
    a_header_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_HEADER)
            |-> (r_out.last == (r_out.payload_length == '0)))
        else $error("header last flag disagrees with length");

    // In the payload phase at least one byte is still due.
    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_pay_left != '0))
        else $error("payload phase with zero bytes left");

    // A stalled result is never overwritten by the parse step.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !w_fire)
        else $error("parse step fired while the result register was stalled");

endmodule
